>>> sv/dbcs_pkg.sv
package dbcs_pkg;

  localparam int TABLE_ADDR_BITS = 16;
  localparam int CODE_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_CHARSET_MODE = 1'b0;

  typedef enum logic {
    OP_TEXT        = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } opcode_t;

  typedef enum logic {
    CS_GBK  = 1'b0,
    CS_BIG5 = 1'b1
  } charset_t;

  localparam logic [7:0] GBK_LEAD_LO   = 8'd129;
  localparam logic [7:0] GBK_LEAD_HI   = 8'd254;
  localparam logic [7:0] GBK_TRAIL_LO  = 8'd64;
  localparam logic [7:0] GBK_TRAIL_HI  = 8'd254;
  localparam logic [7:0] GBK_TRAIL_GAP = 8'd127;
  localparam logic [7:0] B5_LEAD_LO    = 8'd161;
  localparam logic [7:0] B5_LEAD_HI    = 8'd249;
  localparam logic [7:0] B5_TRAIL1_LO  = 8'd64;
  localparam logic [7:0] B5_TRAIL1_HI  = 8'd126;
  localparam logic [7:0] B5_TRAIL2_LO  = 8'd161;
  localparam logic [7:0] B5_TRAIL2_HI  = 8'd254;
  localparam logic [7:0] ASCII_MAX     = 8'd127;

  localparam logic [CODE_BITS-1:0] UTF8_ONE_MAX = 16'd127;
  localparam logic [CODE_BITS-1:0] UTF8_TWO_MAX = 16'd2047;

  // one pending result run
  typedef struct packed {
    logic       lookup;
    logic [7:0] raw0;
    logic [7:0] raw1;
    logic [1:0] raw_count;
    logic       eot;
  } run_desc_t;

  function automatic logic is_lead(input logic [7:0] b, input logic mode);
    logic r;
    if (mode == CS_GBK) begin
      r = (b >= GBK_LEAD_LO) && (b <= GBK_LEAD_HI);
    end else begin
      r = (b >= B5_LEAD_LO) && (b <= B5_LEAD_HI);
    end
    return r;
  endfunction

  function automatic logic is_trail(input logic [7:0] b, input logic mode);
    logic r;
    if (mode == CS_GBK) begin
      r = (b >= GBK_TRAIL_LO) && (b <= GBK_TRAIL_HI) && (b != GBK_TRAIL_GAP);
    end else begin
      r = ((b >= B5_TRAIL1_LO) && (b <= B5_TRAIL1_HI)) ||
          ((b >= B5_TRAIL2_LO) && (b <= B5_TRAIL2_HI));
    end
    return r;
  endfunction

  function automatic logic [1:0] utf8_len(input logic [CODE_BITS-1:0] v);
    logic [1:0] n;
    if (v <= UTF8_ONE_MAX) begin
      n = 2'd1;
    end else if (v <= UTF8_TWO_MAX) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CODE_BITS-1:0] v,
                                           input logic [1:0] k);
    logic [1:0] n;
    logic [7:0] r;
    n = utf8_len(v);
    r = v[7:0];
    if (n == 2'd2) begin
      r = (k == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
    end else if (n == 2'd3) begin
      case (k)
        2'd0:    r = {4'b1110, v[15:12]};
        2'd1:    r = {2'b10, v[11:6]};
        default: r = {2'b10, v[5:0]};
      endcase
    end
    return r;
  endfunction

endpackage

>>> sv/dbcs_stream_if.sv
interface dbcs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  in_byte;
  logic        end_of_text;
  logic [15:0] table_index;
  logic [15:0] table_value;

  modport source (output valid, opcode, in_byte, end_of_text, table_index, table_value,
                  input ready);
  modport sink (input valid, opcode, in_byte, end_of_text, table_index, table_value,
                output ready);
endinterface

interface dbcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, out_byte, run_last, text_done, input ready);
  modport sink (input valid, out_byte, run_last, text_done, output ready);
endinterface

>>> sv/dbcs_table_ram.sv
module dbcs_table_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/dbcs_front.sv
module dbcs_front (
  input  logic                                clk,
  input  logic                                rst,
  dbcs_in_if.sink                             in_ch,
  input  logic                                charset_mode,
  input  logic                                take,
  output logic                                ram_we,
  output logic [dbcs_pkg::TABLE_ADDR_BITS-1:0] ram_waddr,
  output logic [dbcs_pkg::CODE_BITS-1:0]      ram_wdata,
  output logic                                ram_re,
  output logic [dbcs_pkg::TABLE_ADDR_BITS-1:0] ram_raddr,
  output logic                                desc_load,
  output dbcs_pkg::run_desc_t                 desc
);

  logic       held_valid;
  logic [7:0] held_lead;
  logic       held_valid_next;
  logic [7:0] held_lead_next;
  logic       accept;
  logic       text;
  logic       pair;
  logic       capture;
  logic [15:0] pair_code;

  assign in_ch.ready = take;
  assign accept = in_ch.valid && take;
  assign text = accept && (in_ch.opcode == dbcs_pkg::OP_TEXT);

  assign pair = held_valid && dbcs_pkg::is_trail(in_ch.in_byte, charset_mode);
  assign capture = (in_ch.in_byte > dbcs_pkg::ASCII_MAX) &&
                   dbcs_pkg::is_lead(in_ch.in_byte, charset_mode) && !in_ch.end_of_text;
  assign pair_code = {held_lead, in_ch.in_byte};

  assign ram_we = accept && (in_ch.opcode == dbcs_pkg::OP_TABLE_WRITE);
  assign ram_waddr = in_ch.table_index[dbcs_pkg::TABLE_ADDR_BITS-1:0];
  assign ram_wdata = in_ch.table_value;
  assign ram_re = text && pair;
  assign ram_raddr = pair_code[dbcs_pkg::TABLE_ADDR_BITS-1:0];

  always_comb begin
    held_valid_next = held_valid;
    held_lead_next = held_lead;
    desc.lookup = pair;
    desc.raw0 = held_valid ? held_lead : in_ch.in_byte;
    desc.raw1 = in_ch.in_byte;
    desc.raw_count = {1'b0, held_valid} + {1'b0, !capture};
    desc.eot = in_ch.end_of_text;
    desc_load = 1'b0;
    if (text) begin
      if (pair) begin
        desc_load = 1'b1;
        held_valid_next = 1'b0;
        held_lead_next = '0;
      end else begin
        desc_load = held_valid || !capture;
        held_valid_next = capture;
        held_lead_next = capture ? in_ch.in_byte : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_lead <= '0;
    end else begin
      held_valid <= held_valid_next;
      held_lead <= held_lead_next;
    end
  end

  a_write_no_run: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !desc_load && !ram_re && (held_valid_next == held_valid) &&
               (held_lead_next == held_lead))
    else $error("table write started a run");

  a_held_after_capture: assert property (@(posedge clk) disable iff (rst)
    (text && !pair && capture) |=> held_valid)
    else $error("lead byte not held");

endmodule

>>> sv/dbcs_serializer.sv
module dbcs_serializer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           desc_load,
  input  dbcs_pkg::run_desc_t            desc,
  input  logic [dbcs_pkg::CODE_BITS-1:0] rdata,
  output logic                           free,
  dbcs_out_if.source                     out_ch
);

  logic                s2_valid;
  dbcs_pkg::run_desc_t s2_desc;
  logic [1:0]          idx;
  logic [1:0]          run_len;
  logic [7:0]          cur_byte;
  logic                load;
  logic                last_load;
  logic                ovalid;
  logic [7:0]          obyte;
  logic                olast;
  logic                odone;

  assign run_len = s2_desc.lookup ? dbcs_pkg::utf8_len(rdata) : s2_desc.raw_count;

  always_comb begin
    if (s2_desc.lookup) begin
      cur_byte = dbcs_pkg::utf8_byte(rdata, idx);
    end else begin
      cur_byte = (idx == 2'd0) ? s2_desc.raw0 : s2_desc.raw1;
    end
  end

  assign load = s2_valid && (!ovalid || out_ch.ready);
  assign last_load = load && (idx == run_len - 2'd1);
  assign free = !s2_valid || last_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      idx <= '0;
    end else if (desc_load) begin
      s2_valid <= 1'b1;
      idx <= '0;
    end else if (last_load) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_load) begin
      s2_desc <= desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= cur_byte;
      olast <= last_load;
      odone <= last_load && s2_desc.eot;
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.out_byte = obyte;
  assign out_ch.run_last = olast;
  assign out_ch.text_done = odone;

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    desc_load |-> free)
    else $error("run loaded over a busy one");

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (idx < run_len))
    else $error("byte index past end of run");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (!odone || olast))
    else $error("text end flagged on inner byte");

  a_run_captured: assert property (@(posedge clk) disable iff (rst)
    desc_load |=> s2_valid && (idx == 2'd0))
    else $error("run not captured");

endmodule

>>> sv/dbcs_to_utf8_transcoder_core.sv
// GBK/Big5 to UTF-8 transcoder. Items arrive on in_ch: text bytes, or writes into the
// 64K x 16 code table, which must be loaded before any text that reads an entry. The
// charset is chosen by the charset_mode register at APB address 0 (0 GBK, 1 Big5),
// to be written only while idle; the block does not enforce this. An item is taken only
// while the serializer is free; result bytes go out one per cycle while out_ch is
// ready, via a single output register; an item yielding n bytes (at most 3) holds the
// input until its last byte is loaded, and items yielding one byte or none sustain one
// item per cycle while out_ch is ready. Lookup or not, the first result byte goes from
// the run register to the output; the table is read at acceptance and never cleared.
module dbcs_to_utf8_transcoder_core (
  input  logic                                clk,
  input  logic                                rst,
  dbcs_in_if.sink                             in_ch,
  dbcs_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dbcs_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [dbcs_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [dbcs_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);

  logic                                 charset_mode;
  logic                                 take;
  logic                                 ram_we;
  logic [dbcs_pkg::TABLE_ADDR_BITS-1:0] ram_waddr;
  logic [dbcs_pkg::CODE_BITS-1:0]       ram_wdata;
  logic                                 ram_re;
  logic [dbcs_pkg::TABLE_ADDR_BITS-1:0] ram_raddr;
  logic [dbcs_pkg::CODE_BITS-1:0]       ram_rdata;
  logic                                 desc_load;
  dbcs_pkg::run_desc_t                  desc;
  logic                                 reg_sel;

  assign pready = 1'b1;
  assign reg_sel = (paddr[dbcs_pkg::CFG_ADDR_BITS-1] == dbcs_pkg::REG_CHARSET_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_mode <= dbcs_pkg::CS_GBK;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      charset_mode <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {{(dbcs_pkg::CFG_DATA_BITS-1){1'b0}}, charset_mode} : '0;

  dbcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .charset_mode (charset_mode),
    .take         (take),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .desc_load    (desc_load),
    .desc         (desc)
  );

  dbcs_table_ram #(
    .ADDR_BITS (dbcs_pkg::TABLE_ADDR_BITS),
    .DATA_BITS (dbcs_pkg::CODE_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dbcs_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .desc_load (desc_load),
    .desc      (desc),
    .rdata     (ram_rdata),
    .free      (take),
    .out_ch    (out_ch)
  );

endmodule
